>>> rtl/sca_pkg.sv
// Shared types, constants and codes of the size-class slab allocator.
package sca_pkg;

	localparam int PAGE_BYTES   = 4096;
	localparam int SIZE_CLASSES = 9;
	localparam int FREE_DEPTH   = 512;

	localparam int MIN_OBJ   = 8;
	localparam int MIN_SHIFT = 3;

	localparam int ADDR_W    = 48;
	localparam int REQ_W     = 16;
	localparam int CLS_OUT_W = 4;
	localparam int STATUS_W  = 3;

	localparam int PAGE_BITS = $clog2(PAGE_BYTES);
	localparam int PN_W      = ADDR_W - PAGE_BITS;
	localparam int OFF_W     = PAGE_BITS + 1;
	localparam int CNT_W     = $clog2(FREE_DEPTH + 1);
	localparam int FD_BITS   = $clog2(FREE_DEPTH);
	localparam int CLS_IW    = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
	localparam int OBJ_W     = MIN_SHIFT + SIZE_CLASSES;
	localparam int SUM_W     = ((OBJ_W > OFF_W) ? OBJ_W : OFF_W) + 1;
	localparam int CMP_W     = REQ_W + 1;
	localparam int MEM_AW    = CLS_IW + FD_BITS;
	localparam int MEM_DEPTH = SIZE_CLASSES * (1 << FD_BITS);

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_FROM_LIST    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FROM_BUMP    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FREED        = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CLASS_FULL   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_UNKNOWN_PAGE = 3'd5;
	localparam logic [STATUS_W-1:0] ST_LIST_FULL    = 3'd6;

	typedef struct packed {
		logic              command;
		logic [REQ_W-1:0]  request_size;
		logic [ADDR_W-1:0] free_addr;
	} sca_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]    result_addr;
		logic [CLS_OUT_W-1:0] size_class;
		logic [STATUS_W-1:0]  status;
	} sca_rsp_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic commit;
	} sca_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_full;
	} sca_stat_t;

endpackage

>>> rtl/sca_ctrl.sv
// Request sequencer of the size-class slab allocator.
module sca_ctrl import sca_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      out_stall,
	input  sca_stat_t stat,
	output sca_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd.accept = in_valid && (state_q == S_IDLE);
		cmd.commit = (state_q == S_EXEC) && (!stat.out_full || !out_stall);
		in_stall   = (state_q != S_IDLE);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				// hold until the result slot frees up
				if (cmd.commit) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

>>> rtl/sca_datapath.sv
// Class decode, per-class counters, free-list memory and result register.
module sca_datapath import sca_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [ADDR_W-1:0] cfg_wr_data,
	input  sca_req_t          in_data,
	input  sca_cmd_t          cmd,
	output sca_stat_t         stat,
	input  logic              out_stall,
	output logic              out_valid,
	output sca_rsp_t          out_data
);

	logic [ADDR_W-1:0]       heap_base_q;
	logic [SIZE_CLASSES-1:0] page_in_use_q;
	logic [OFF_W-1:0]        bump_offset_q [SIZE_CLASSES];
	logic [CNT_W-1:0]        stack_count_q [SIZE_CLASSES];
	logic [PAGE_BITS-1:0]    mem [MEM_DEPTH];
	logic [PAGE_BITS-1:0]    rdata_q;
	logic                    out_valid_q;
	sca_rsp_t                out_data_q;

	// decoded request
	logic                 cmd_s1;
	logic                 ok_s1;
	logic [CLS_IW-1:0]    cls_s1;
	logic [CNT_W-1:0]     cnt_s1;
	logic [OFF_W-1:0]     off_s1;
	logic [PN_W-1:0]      page_s1;
	logic [PAGE_BITS-1:0] free_off_s1;

	logic [CLS_IW-1:0] alloc_cls, sel_cls;
	logic              alloc_ok, free_ok, sel_ok;
	logic [PN_W-1:0]   page_diff;
	logic [CNT_W-1:0]  cnt_sel;
	logic [MEM_AW-1:0] rd_addr;

	// decode: round size up to a class, or find the page of the freed address
	always_comb begin
		alloc_ok  = 1'b0;
		alloc_cls = '0;
		for (int c = SIZE_CLASSES - 1; c >= 0; c--) begin
			if ({1'b0, in_data.request_size} <= (CMP_W'(MIN_OBJ) << c)) begin
				alloc_ok  = 1'b1;
				alloc_cls = CLS_IW'(c);
			end
		end
		if (in_data.request_size == '0) alloc_ok = 1'b0;

		page_diff = in_data.free_addr[ADDR_W-1:PAGE_BITS] - heap_base_q[ADDR_W-1:PAGE_BITS];
		free_ok   = (page_diff < PN_W'(SIZE_CLASSES)) && page_in_use_q[page_diff[CLS_IW-1:0]];

		if (in_data.command == CMD_FREE) begin
			sel_ok  = free_ok;
			sel_cls = free_ok ? page_diff[CLS_IW-1:0] : '0;
		end else begin
			sel_ok  = alloc_ok;
			sel_cls = alloc_ok ? alloc_cls : '0;
		end

		cnt_sel = stack_count_q[sel_cls];
		rd_addr = {sel_cls, FD_BITS'(cnt_sel - CNT_W'(1))};
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_s1      <= in_data.command;
			ok_s1       <= sel_ok;
			cls_s1      <= sel_cls;
			cnt_s1      <= cnt_sel;
			off_s1      <= bump_offset_q[sel_cls];
			page_s1     <= heap_base_q[ADDR_W-1:PAGE_BITS] + PN_W'(sel_cls);
			free_off_s1 <= in_data.free_addr[PAGE_BITS-1:0];
		end
	end

	// commit: pick the result and the state update
	sca_rsp_t          rsp;
	logic              piu_set, off_we, cnt_we, mem_we;
	logic [OFF_W-1:0]  off_new;
	logic [CNT_W-1:0]  cnt_new;
	logic [SUM_W-1:0]  obj_size, bump_sum;

	always_comb begin
		rsp.result_addr = '0;
		rsp.size_class  = '0;
		rsp.status      = ST_BAD_SIZE;
		piu_set  = 1'b0;
		off_we   = 1'b0;
		cnt_we   = 1'b0;
		mem_we   = 1'b0;
		off_new  = off_s1;
		cnt_new  = cnt_s1;
		obj_size = SUM_W'(MIN_OBJ) << cls_s1;
		bump_sum = SUM_W'(off_s1) + obj_size;

		if (cmd_s1 == CMD_ALLOC) begin
			if (ok_s1) begin
				piu_set        = 1'b1;
				rsp.size_class = CLS_OUT_W'(cls_s1);
				if (cnt_s1 != '0) begin
					cnt_we          = 1'b1;
					cnt_new         = cnt_s1 - CNT_W'(1);
					rsp.result_addr = {page_s1, rdata_q};
					rsp.status      = ST_FROM_LIST;
				end else if (bump_sum <= SUM_W'(PAGE_BYTES)) begin
					off_we          = 1'b1;
					off_new         = OFF_W'(bump_sum);
					rsp.result_addr = {page_s1, off_s1[PAGE_BITS-1:0]};
					rsp.status      = ST_FROM_BUMP;
				end else begin
					rsp.status = ST_CLASS_FULL;
				end
			end
		end else begin
			if (!ok_s1) begin
				rsp.status = ST_UNKNOWN_PAGE;
			end else begin
				rsp.size_class = CLS_OUT_W'(cls_s1);
				if (cnt_s1 >= CNT_W'(FREE_DEPTH)) begin
					rsp.status = ST_LIST_FULL;
				end else begin
					mem_we     = 1'b1;
					cnt_we     = 1'b1;
					cnt_new    = cnt_s1 + CNT_W'(1);
					rsp.status = ST_FREED;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) rdata_q <= mem[rd_addr];
		if (cmd.commit && mem_we) mem[{cls_s1, cnt_s1[FD_BITS-1:0]}] <= free_off_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q   <= '0;
			page_in_use_q <= '0;
			for (int c = 0; c < SIZE_CLASSES; c++) begin
				bump_offset_q[c] <= '0;
				stack_count_q[c] <= '0;
			end
		end else begin
			if (cfg_wr_en) heap_base_q <= cfg_wr_data;
			if (cmd.commit) begin
				if (piu_set) page_in_use_q[cls_s1] <= 1'b1;
				if (off_we)  bump_offset_q[cls_s1] <= off_new;
				if (cnt_we)  stack_count_q[cls_s1] <= cnt_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.commit) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) out_data_q <= rsp;
	end

	assign stat.out_full = out_valid_q;
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;

endmodule

>>> rtl/size_class_slab_allocator.sv
// Top level of the size-class slab allocator: sequencer plus datapath.
//
//  Channel   Signals                           Moves
//  --------  --------------------------------  -----------------------------------
//  in        in_valid, in_stall, in_data       one allocate or free request
//  out       out_valid, out_stall, out_data    one result per request
//  cfg       cfg_wr_en, cfg_wr_data            heap_base
//
// The accept cycle decodes the class and reads the free-list memory; the commit
// step, held while the output register is full and stalled, commits counters,
// the push and the result; the synchronous memory read sets this split.
// Reset clears the page, bump and count registers at once; the free-list
// memory is never cleared, since only pushed entries are popped.
// A result waits in the output register while the next request is accepted;
// the commit of that request holds until the output register drains.
module size_class_slab_allocator import sca_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [ADDR_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  sca_req_t          in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output sca_rsp_t          out_data
);

	// command and status between sequencer and datapath
	sca_cmd_t  cmd;
	sca_stat_t stat;

	// sequencer: accept in idle, commit once the result slot is free
	sca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: class decode, per-class state, free lists, result register
	sca_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.cmd         (cmd),
		.stat        (stat),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_data    (out_data)
	);

endmodule
